[rtl/transparent_rle_line_encoder_defines.svh]
// Assertion macros shared by the line encoder RTL.
`ifndef TRANSPARENT_RLE_LINE_ENCODER_DEFINES_SVH
`define TRANSPARENT_RLE_LINE_ENCODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RTLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define RTLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rtle_pkg.sv]
// Shared types, constants and helpers of the transparent RLE line encoder.
`default_nettype none

package rtle_pkg;

  localparam int PIX_W     = 8;
  localparam int LEN_W     = 7;
  localparam int CNT_W     = 4;
  localparam int WORD_BYTES = 8;

  localparam int SOLID_MAX  = 127;
  localparam int TRANSP_MAX = 128;

  localparam int BYTES_PER_RESULT_DEF = 8;
  localparam int QUEUE_DEPTH_DEF      = 4;

  localparam logic [PIX_W-1:0] TRANSP_FULL_CODE = 8'h80;
  localparam logic [PIX_W-1:0] TRANSP_CODE_TOP  = 8'hFF;

  // One queue entry: all output of one pixel, in order pre byte, run, post byte.
  typedef struct packed {
    logic             pre_v;
    logic [PIX_W-1:0] pre_b;
    logic [LEN_W-1:0] run_n;
    logic             post_v;
    logic [PIX_W-1:0] post_b;
  } cmd_t;

  // Code byte of a partial transparent run of n pixels: 0xFF - (n - 1).
  function automatic logic [PIX_W-1:0] tcode(input logic [LEN_W-1:0] n);
    return TRANSP_CODE_TOP - {1'b0, n} + 8'd1;
  endfunction

endpackage

`default_nettype wire

[rtl/rtle_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rtle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

[rtl/rtle_fifo.sv]
// Short command queue between the classifying front and the emitting back.
`default_nettype none
`include "transparent_rle_line_encoder_defines.svh"

module rtle_fifo #(
  parameter int DEPTH = rtle_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_i,
  input  rtle_pkg::cmd_t     push_data_i,
  input  wire logic          pop_i,
  output rtle_pkg::cmd_t     head_o,
  output logic               empty_o,
  output logic               full_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  rtle_pkg::cmd_t  slot_r [DEPTH];
  logic [PW-1:0]   wptr_r, wptr_nxt;
  logic [PW-1:0]   rptr_r, rptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push_i) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop_i) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
    if (push_i) begin
      slot_r[wptr_r] <= push_data_i;
    end
  end

  assign head_o  = slot_r[rptr_r];
  assign empty_o = (count_r == '0);
  assign full_o  = (count_r == CW'(DEPTH));

  `RTLE_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop_i, count_r != '0, "pop from empty queue")
  `RTLE_ASSERT_IMP(a_no_push_full, clk, rst_n, push_i, count_r != CW'(DEPTH), "push into full queue")

endmodule

`default_nettype wire

[rtl/rtle_front.sv]
// Front end: takes pixels, tracks open runs, buffers solid pixels, queues commands.
`default_nettype none
`include "transparent_rle_line_encoder_defines.svh"

module rtle_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [rtle_pkg::PIX_W-1:0]    cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rtle_pkg::PIX_W-1:0]    in_pixel,
  input  wire logic                          in_line_end,
  input  wire logic                          q_full_i,
  output logic                               push_o,
  output rtle_pkg::cmd_t                     cmd_o,
  output logic                               ram_we_o,
  output logic [rtle_pkg::LEN_W-1:0]         ram_waddr_o,
  output logic [rtle_pkg::PIX_W-1:0]         ram_wdata_o,
  input  wire logic                          run_done_i
);

  logic [rtle_pkg::PIX_W-1:0] tidx_r;
  logic [rtle_pkg::LEN_W-1:0] tlen_r, tlen_nxt;
  logic [rtle_pkg::LEN_W-1:0] slen_r, slen_nxt;
  logic                       busy_r, busy_nxt;

  logic                       is_transp;
  logic                       accept;
  logic [rtle_pkg::LEN_W:0]   t_sum;
  logic [rtle_pkg::LEN_W-1:0] s_inc;
  logic                       solid_wr;
  rtle_pkg::cmd_t             cmd;

  assign is_transp = (in_pixel == tidx_r);
  // Hold solid pixels while the buffer is still being read out.
  assign in_stall  = q_full_i || (!is_transp && busy_r);
  assign accept    = in_valid && !in_stall;

  always_comb begin
    cmd      = '0;
    tlen_nxt = tlen_r;
    slen_nxt = slen_r;
    solid_wr = 1'b0;
    t_sum    = {1'b0, tlen_r} + 1'b1;
    s_inc    = slen_r + 1'b1;
    if (is_transp) begin
      // Close any open solid run first.
      cmd.run_n = slen_r;
      slen_nxt  = '0;
      if (t_sum == (rtle_pkg::LEN_W + 1)'(rtle_pkg::TRANSP_MAX)) begin
        cmd.post_v = 1'b1;
        cmd.post_b = rtle_pkg::TRANSP_FULL_CODE;
        tlen_nxt   = '0;
      end else begin
        tlen_nxt = t_sum[rtle_pkg::LEN_W-1:0];
      end
      if (in_line_end && tlen_nxt != '0) begin
        cmd.post_v = 1'b1;
        cmd.post_b = rtle_pkg::tcode(tlen_nxt);
      end
    end else begin
      if (tlen_r != '0) begin
        cmd.pre_v = 1'b1;
        cmd.pre_b = rtle_pkg::tcode(tlen_r);
      end
      tlen_nxt = '0;
      solid_wr = 1'b1;
      if (s_inc == rtle_pkg::LEN_W'(rtle_pkg::SOLID_MAX) || in_line_end) begin
        cmd.run_n = s_inc;
        slen_nxt  = '0;
      end else begin
        slen_nxt = s_inc;
      end
    end
    if (in_line_end) begin
      tlen_nxt = '0;
      slen_nxt = '0;
    end
  end

  assign push_o      = accept && (cmd.pre_v || cmd.run_n != '0 || cmd.post_v);
  assign cmd_o       = cmd;
  assign ram_we_o    = accept && solid_wr;
  assign ram_waddr_o = slen_r;
  assign ram_wdata_o = in_pixel;

  always_comb begin
    busy_nxt = busy_r;
    if (run_done_i) begin
      busy_nxt = 1'b0;
    end
    if (push_o && cmd.run_n != '0) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tidx_r <= '0;
      tlen_r <= '0;
      slen_r <= '0;
      busy_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tidx_r <= cfg_wr_data;
      end
      if (accept) begin
        tlen_r <= tlen_nxt;
        slen_r <= slen_nxt;
      end
      busy_r <= busy_nxt;
    end
  end

  `RTLE_ASSERT_IMP(a_no_write_busy, clk, rst_n, ram_we_o, !busy_r, "buffer written during readout")

endmodule

`default_nettype wire

[rtl/rtle_back.sv]
// Back end: expands queued commands into bytes and packs them into results.
`default_nettype none
`include "transparent_rle_line_encoder_defines.svh"

module rtle_back #(
  parameter int BYTES_PER_RESULT = rtle_pkg::BYTES_PER_RESULT_DEF
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  rtle_pkg::cmd_t                                    head_i,
  input  wire logic                                         empty_i,
  output logic                                              pop_o,
  output logic                                              rd_en_o,
  output logic [rtle_pkg::LEN_W-1:0]                        rd_addr_o,
  input  wire logic [rtle_pkg::PIX_W-1:0]                   rd_data_i,
  output logic                                              run_done_o,
  output logic                                              out_valid,
  input  wire logic                                         out_stall,
  output logic [rtle_pkg::WORD_BYTES*rtle_pkg::PIX_W-1:0]   out_packed_bytes,
  output logic [rtle_pkg::CNT_W-1:0]                        out_byte_count,
  output logic                                              out_last
);

  localparam int WB = rtle_pkg::WORD_BYTES;
  localparam int PW = rtle_pkg::PIX_W;
  localparam logic [rtle_pkg::CNT_W-1:0] CNT_LAST = rtle_pkg::CNT_W'(BYTES_PER_RESULT - 1);

  typedef enum logic [2:0] {ST_IDLE, ST_PRE, ST_CNT, ST_PIX, ST_POST} state_t;

  state_t                      state_r, state_nxt;
  rtle_pkg::cmd_t              cur_r, cur_nxt;
  logic [rtle_pkg::LEN_W-1:0]  idx_r, idx_nxt;

  logic                        s1_valid_r, s1_valid_nxt;
  logic                        s1_ram_r, s1_ram_nxt;
  logic [PW-1:0]               s1_byte_r, s1_byte_nxt;
  logic                        s1_last_r, s1_last_nxt;

  logic [WB*PW-1:0]            acc_r, acc_nxt;
  logic [rtle_pkg::CNT_W-1:0]  acc_cnt_r, acc_cnt_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [WB*PW-1:0]            out_data_r, out_data_nxt;
  logic [rtle_pkg::CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        tok_ram, tok_last, last_pix;
  logic [PW-1:0]               tok_byte;
  logic                        s0_adv, s1_adv, completes, out_free;
  logic [PW-1:0]               s1_data;
  logic [WB*PW-1:0]            word_new;

  // Packer: place the stage-one byte, zero the lanes above it.
  assign s1_data   = s1_ram_r ? rd_data_i : s1_byte_r;
  assign completes = s1_last_r || (acc_cnt_r == CNT_LAST);
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && (!completes || out_free);
  assign s0_adv    = !s1_valid_r || s1_adv;
  assign last_pix  = (idx_r == cur_r.run_n - 1'b1);

  always_comb begin
    for (int k = 0; k < WB; k++) begin
      if (3'(k) == acc_cnt_r[2:0]) begin
        word_new[k*PW +: PW] = s1_data;
      end else if (rtle_pkg::CNT_W'(k) < acc_cnt_r) begin
        word_new[k*PW +: PW] = acc_r[k*PW +: PW];
      end else begin
        word_new[k*PW +: PW] = '0;
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    idx_nxt      = idx_r;
    pop_o        = 1'b0;
    tok_ram      = 1'b0;
    tok_byte     = '0;
    tok_last     = 1'b0;
    run_done_o   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          cur_nxt = head_i;
          if (head_i.pre_v) begin
            state_nxt = ST_PRE;
          end else if (head_i.run_n != '0) begin
            state_nxt = ST_CNT;
          end else begin
            state_nxt = ST_POST;
          end
        end
      end
      ST_PRE: begin
        tok_byte = cur_r.pre_b;
        tok_last = (cur_r.run_n == '0) && !cur_r.post_v;
        if (s0_adv) begin
          if (cur_r.run_n != '0) begin
            state_nxt = ST_CNT;
          end else if (cur_r.post_v) begin
            state_nxt = ST_POST;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_CNT: begin
        tok_byte = {1'b0, cur_r.run_n};
        if (s0_adv) begin
          state_nxt = ST_PIX;
          idx_nxt   = '0;
        end
      end
      ST_PIX: begin
        tok_ram  = 1'b1;
        tok_last = last_pix && !cur_r.post_v;
        if (s0_adv) begin
          idx_nxt = idx_r + 1'b1;
          if (last_pix) begin
            run_done_o = 1'b1;
            state_nxt  = cur_r.post_v ? ST_POST : ST_IDLE;
          end
        end
      end
      ST_POST: begin
        tok_byte = cur_r.post_b;
        tok_last = 1'b1;
        if (s0_adv) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign rd_en_o   = s0_adv && tok_ram && (state_r == ST_PIX);
  assign rd_addr_o = idx_r;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_ram_nxt    = s1_ram_r;
    s1_byte_nxt   = s1_byte_r;
    s1_last_nxt   = s1_last_r;
    acc_nxt       = acc_r;
    acc_cnt_nxt   = acc_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    if (s0_adv) begin
      s1_valid_nxt = (state_r != ST_IDLE);
      s1_ram_nxt   = tok_ram;
      s1_byte_nxt  = tok_byte;
      s1_last_nxt  = tok_last;
    end
    if (s1_adv) begin
      if (completes) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = word_new;
        out_cnt_nxt   = acc_cnt_r + 1'b1;
        out_last_nxt  = s1_last_r;
        acc_cnt_nxt   = '0;
      end else begin
        acc_nxt     = word_new;
        acc_cnt_nxt = acc_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s1_valid_r  <= 1'b0;
      acc_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s1_valid_r  <= s1_valid_nxt;
      acc_cnt_r   <= acc_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r      <= cur_nxt;
    idx_r      <= idx_nxt;
    s1_ram_r   <= s1_ram_nxt;
    s1_byte_r  <= s1_byte_nxt;
    s1_last_r  <= s1_last_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_packed_bytes = out_data_r;
  assign out_byte_count   = out_cnt_r;
  assign out_last         = out_last_r;

  `RTLE_ASSERT_IMP(a_full_unless_last, clk, rst_n, out_valid_r && !out_last_r, out_cnt_r == rtle_pkg::CNT_W'(BYTES_PER_RESULT), "short result before the last")
  `RTLE_ASSERT_NXT(a_ram_hold, clk, rst_n, s1_valid_r && s1_ram_r && !s1_adv, $stable(rd_data_i), "buffer data moved under a stalled byte")
  `RTLE_ASSERT_NXT(a_pop_loads, clk, rst_n, pop_o, state_r != ST_IDLE, "popped command not taken up")

endmodule

`default_nettype wire

[rtl/transparent_rle_line_encoder.sv]
// A pixel's command passes the queue, the back's command and stage-one registers, then the output register.
// Throughput: one pixel per cycle while the queue has room and no solid run is being read.
// A solid pixel waits while the run buffer drains, one byte a cycle while the output is not stalled.
// The back takes up each queued command in its idle state; 17 results at most per pixel.
// Reset (synchronous, rst_n low): runs, queue and outputs clear, transparent index is 0.
// The run buffer is not cleared; no clearing pass is needed.
`default_nettype none

module transparent_rle_line_encoder #(
  parameter int BYTES_PER_RESULT = rtle_pkg::BYTES_PER_RESULT_DEF,
  parameter int QUEUE_DEPTH      = rtle_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  // configuration: transparent palette index
  input  wire logic                                         cfg_wr_en,
  input  wire logic [rtle_pkg::PIX_W-1:0]                   cfg_wr_data,
  // pixel beats
  input  wire logic                                         in_valid,
  output logic                                              in_stall,
  input  wire logic [rtle_pkg::PIX_W-1:0]                   in_pixel,
  input  wire logic                                         in_line_end,
  // packed result beats
  output logic                                              out_valid,
  input  wire logic                                         out_stall,
  output logic [rtle_pkg::WORD_BYTES*rtle_pkg::PIX_W-1:0]   out_packed_bytes,
  output logic [rtle_pkg::CNT_W-1:0]                        out_byte_count,
  output logic                                              out_last
);

  // Front to queue
  logic                        push;
  rtle_pkg::cmd_t              push_cmd;
  logic                        q_full;
  // Queue to back
  rtle_pkg::cmd_t              head_cmd;
  logic                        q_empty;
  logic                        pop;
  // Solid run buffer: front writes, back reads
  logic                        ram_we;
  logic [rtle_pkg::LEN_W-1:0]  ram_waddr;
  logic [rtle_pkg::PIX_W-1:0]  ram_wdata;
  logic                        ram_re;
  logic [rtle_pkg::LEN_W-1:0]  ram_raddr;
  logic [rtle_pkg::PIX_W-1:0]  ram_rdata;
  // Back tells the front the buffer is free again
  logic                        run_done;

  // Front: classify each pixel beat against the transparent index, extend or
  // close the open run, write solid pixels to the buffer and queue one
  // command per beat that produces output.
  rtle_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_pixel    (in_pixel),
    .in_line_end (in_line_end),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .run_done_i  (run_done)
  );

  // Decouple the two halves so a stalled output does not block transparent pixels.
  rtle_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .head_o      (head_cmd),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  // Pixels of the open solid run; only entries below the run length are read.
  rtle_ram #(
    .WIDTH (rtle_pkg::PIX_W),
    .DEPTH (rtle_pkg::SOLID_MAX)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Back: walk each command byte by byte (pre byte, count, pixels, post byte)
  // and pack BYTES_PER_RESULT bytes per result beat, fewer only in the flagged final one.
  rtle_back #(
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_i           (head_cmd),
    .empty_i          (q_empty),
    .pop_o            (pop),
    .rd_en_o          (ram_re),
    .rd_addr_o        (ram_raddr),
    .rd_data_i        (ram_rdata),
    .run_done_o       (run_done),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_packed_bytes (out_packed_bytes),
    .out_byte_count   (out_byte_count),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire
